/* rtl/sssh_pkg.sv */
// Package for the swept-sphere segment hit unit: word types, sideband struct
// and fixed widths shared by the pipeline cells and the top level. No dependencies.
`default_nettype none

package sssh_pkg;

  localparam logic [15:0] RADIUS_RESET   = 16'd1475;
  localparam int          DIR_FRAC_SHIFT = 14;
  // Root of the discriminant is below 2^37; quotient of interest is below 2^19.
  localparam int          ISQ_CELLS      = 37;
  localparam int          DIV_CELLS      = 19;
  localparam int          DISC_W         = 74;
  localparam int          ROOT_W         = 37;
  localparam int          NUM_W          = ROOT_W + DIR_FRAC_SHIFT;

  typedef struct packed {
    logic signed [19:0] target_x;
    logic signed [19:0] target_y;
    logic signed [19:0] target_z;
    logic signed [19:0] start_x;
    logic signed [19:0] start_y;
    logic signed [19:0] start_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [18:0]        seg_length;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic        overlap_at_start;
    logic [18:0] hit_length;
  } out_t;

  // Status that travels with each query through the cell chains.
  typedef struct packed {
    logic                done;
    logic                hit;
    logic                ovl;
    logic [31:0]         a;
    logic [ROOT_W-1:0]   babs;
    logic [18:0]         len;
  } side_t;

endpackage

`default_nettype wire

/* rtl/swept_sphere_segment_hit_unit.sv */
// Top level of the swept-sphere segment hit unit: front-end arithmetic pipeline,
// square root and divider cell chains. Depends on sssh_pkg, sssh_isqrt_cell, sssh_div_cell.
`default_nettype none

// Each input word describes a sphere moving from a start centre along a direction
// for a given length, and a stationary sphere of the same radius. The unit reports
// whether they touch within the segment and, if so, how far the mover travels first.
// Spheres that already overlap give a hit of length zero with overlap_at_start set.
// The unit is fully pipelined and accepts one word in every cycle in which the output
// is not stalled; each word passes 64 registers on its way to the output: six
// arithmetic stages, a chain of 37 square-root cells (one root bit each), one stage
// forming the numerator and a chain of 19 divider cells (one quotient bit each), then
// the output register. All stages
// advance together and hold while a finished result waits for out_ready, so in_ready
// is high whenever the output register is empty or being taken. The radius register
// is written through cfg_we and cfg_wdata and should only change while the unit is idle.

module swept_sphere_segment_hit_unit import sssh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_word,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  logic        en;
  logic [15:0] radius_r;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  // Stage 1: centre offsets and squared contact distance.
  logic               v1_r;
  logic signed [20:0] dpx_r, dpy_r, dpz_r;
  logic signed [15:0] dx1_r, dy1_r, dz1_r;
  logic [18:0]        len1_r;
  logic [33:0]        rr1_r;
  logic [16:0]        two_r;

  assign two_r = {radius_r, 1'b0};

  // Stage 2: products.
  logic               v2_r;
  logic signed [41:0] sqx_r, sqy_r, sqz_r;
  logic signed [36:0] pbx_r, pby_r, pbz_r;
  logic signed [31:0] ddx_r, ddy_r, ddz_r;
  logic [18:0]        len2_r;
  logic [33:0]        rr2_r;

  // Stage 3: sums.
  logic               v3_r;
  logic [42:0]        dpsq_r;
  logic [31:0]        a3_r;
  logic signed [38:0] b3_r;
  logic [18:0]        len3_r;
  logic [33:0]        rr3_r;

  // Stage 4: overlap test and early misses.
  logic        v4_r;
  logic [41:0] c4_r;
  side_t       s4_r;
  logic [42:0] c_full;
  logic [38:0] b_neg;
  logic        ovl_nxt;

  // Stage 5: partial products of B*B and A*C.
  logic        v5_r;
  logic [39:0] bll_r;
  logic [36:0] bhl_r;
  logic [33:0] bhh_r;
  logic [52:0] acl_r, ach_r;
  side_t       s5_r;

  // Stage 6: discriminant.
  logic              v6_r;
  logic [DISC_W-1:0] disc6_r;
  side_t             s6_r;
  side_t             s6_nxt;
  logic [75:0]       bb_sum, ac_sum;

  always_comb begin
    c_full  = dpsq_r - {9'd0, rr3_r};
    b_neg   = -b3_r;
    ovl_nxt = dpsq_r < {9'd0, rr3_r};
    bb_sum  = ({42'd0, bhh_r} << 40) + ({39'd0, bhl_r} << 21) + {36'd0, bll_r};
    ac_sum  = ({23'd0, ach_r} << 21) + {23'd0, acl_r};
    // A negative discriminant means the paths never come close enough.
    s6_nxt  = s5_r;
    if (!s5_r.done && (bb_sum < ac_sum)) begin
      s6_nxt.done = 1'b1;
      s6_nxt.hit  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dpx_r  <= {in_word.start_x[19], in_word.start_x}
                - {in_word.target_x[19], in_word.target_x};
      dpy_r  <= {in_word.start_y[19], in_word.start_y}
                - {in_word.target_y[19], in_word.target_y};
      dpz_r  <= {in_word.start_z[19], in_word.start_z}
                - {in_word.target_z[19], in_word.target_z};
      dx1_r  <= in_word.dir_x;
      dy1_r  <= in_word.dir_y;
      dz1_r  <= in_word.dir_z;
      len1_r <= in_word.seg_length;
      rr1_r  <= two_r * two_r;

      sqx_r  <= dpx_r * dpx_r;
      sqy_r  <= dpy_r * dpy_r;
      sqz_r  <= dpz_r * dpz_r;
      pbx_r  <= dpx_r * dx1_r;
      pby_r  <= dpy_r * dy1_r;
      pbz_r  <= dpz_r * dz1_r;
      ddx_r  <= dx1_r * dx1_r;
      ddy_r  <= dy1_r * dy1_r;
      ddz_r  <= dz1_r * dz1_r;
      len2_r <= len1_r;
      rr2_r  <= rr1_r;

      // Squares are never negative, so the sign bits are zero.
      dpsq_r <= {1'b0, sqx_r} + {1'b0, sqy_r} + {1'b0, sqz_r};
      a3_r   <= ddx_r + ddy_r + ddz_r;
      b3_r   <= 39'(pbx_r) + 39'(pby_r) + 39'(pbz_r);
      len3_r <= len2_r;
      rr3_r  <= rr2_r;

      c4_r      <= c_full[41:0];
      s4_r.ovl  <= ovl_nxt;
      s4_r.hit  <= ovl_nxt;
      // Overlap wins; otherwise a zero length, zero direction or receding path misses.
      s4_r.done <= ovl_nxt || (len3_r == 19'd0) || (a3_r == 32'd0) || (b3_r > 39'sd0);
      s4_r.a    <= a3_r;
      s4_r.babs <= b3_r[38] ? b_neg[ROOT_W-1:0] : b3_r[ROOT_W-1:0];
      s4_r.len  <= len3_r;

      bll_r <= s4_r.babs[19:0] * s4_r.babs[19:0];
      bhl_r <= s4_r.babs[36:20] * s4_r.babs[19:0];
      bhh_r <= s4_r.babs[36:20] * s4_r.babs[36:20];
      acl_r <= s4_r.a * c4_r[20:0];
      ach_r <= s4_r.a * c4_r[41:21];
      s5_r  <= s4_r;

      // The cross term appears twice in B*B, hence the shift by 21 rather than 20.
      disc6_r <= DISC_W'(bb_sum - ac_sum);
      s6_r    <= s6_nxt;
    end
  end

  // Square root chain: cell i settles root bit ISQ_CELLS-1-i.
  logic              iv   [0:ISQ_CELLS];
  logic [DISC_W-1:0] irem [0:ISQ_CELLS];
  logic [ROOT_W-1:0] iroot[0:ISQ_CELLS];
  side_t             iside[0:ISQ_CELLS];

  assign iv[0]    = v6_r;
  assign irem[0]  = disc6_r;
  assign iroot[0] = '0;
  assign iside[0] = s6_r;

  for (genvar i = 0; i < ISQ_CELLS; i++) begin : g_isqrt
    sssh_isqrt_cell #(.K(ISQ_CELLS - 1 - i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (iv[i]),
      .rem_i  (irem[i]),
      .root_i (iroot[i]),
      .side_i (iside[i]),
      .vld_o  (iv[i+1]),
      .rem_o  (irem[i+1]),
      .root_o (iroot[i+1]),
      .side_o (iside[i+1])
    );
  end

  // Numerator stage. A quotient of 2^19 or more always exceeds the segment length,
  // which is the case exactly when num >= a * 2^5; the divider then needs 19 bits only.
  logic              v7_r;
  logic [NUM_W-1:0]  rem7_r;
  side_t             s7_r;
  side_t             s7_nxt;
  logic [ROOT_W-1:0] num;
  side_t             last_side;

  assign last_side = iside[ISQ_CELLS];
  assign num       = last_side.babs - iroot[ISQ_CELLS];

  always_comb begin
    s7_nxt = last_side;
    if (!last_side.done && (num >= {last_side.a, 5'd0})) begin
      s7_nxt.done = 1'b1;
      s7_nxt.hit  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= iv[ISQ_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem7_r <= {num, {DIR_FRAC_SHIFT{1'b0}}};
      s7_r   <= s7_nxt;
    end
  end

  // Divider chain: cell j settles quotient bit DIV_CELLS-1-j.
  logic             dv   [0:DIV_CELLS];
  logic [NUM_W-1:0] drem [0:DIV_CELLS];
  logic [18:0]      dq   [0:DIV_CELLS];
  side_t            dside[0:DIV_CELLS];

  assign dv[0]    = v7_r;
  assign drem[0]  = rem7_r;
  assign dq[0]    = '0;
  assign dside[0] = s7_r;

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    sssh_div_cell #(.J(DIV_CELLS - 1 - j)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (dv[j]),
      .rem_i  (drem[j]),
      .q_i    (dq[j]),
      .side_i (dside[j]),
      .vld_o  (dv[j+1]),
      .rem_o  (drem[j+1]),
      .q_o    (dq[j+1]),
      .side_o (dside[j+1])
    );
  end

  // Output register: the word waits here until it is taken.
  side_t       fin_side;
  logic [18:0] quot;
  out_t        out_word_nxt;

  assign fin_side = dside[DIV_CELLS];
  assign quot     = dq[DIV_CELLS];

  always_comb begin
    out_word_nxt.overlap_at_start = fin_side.ovl;
    out_word_nxt.hit_length       = '0;
    if (fin_side.done) begin
      out_word_nxt.hit = fin_side.hit;
    end else begin
      out_word_nxt.hit = quot <= fin_side.len;
      if (quot <= fin_side.len) begin
        out_word_nxt.hit_length = quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[DIV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= out_word_nxt;
    end
  end

  // An overlap at the start is always reported as a hit.
  a_ovl_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.overlap_at_start |-> out_word.hit)
    else $error("overlap reported without hit");

  // A miss or an overlap carries a zero length.
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_word.hit || out_word.overlap_at_start) |-> out_word.hit_length == 19'd0)
    else $error("nonzero length on miss or overlap");

  // The whole pipeline holds while a result is stalled at the output.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(v7_r))
    else $error("pipeline moved during output stall");

endmodule

`default_nettype wire

/* rtl/sssh_isqrt_cell.sv */
// One digit cell of the pipelined integer square root chain.
// Depends on sssh_pkg.
`default_nettype none

module sssh_isqrt_cell import sssh_pkg::*; #(
  parameter int K = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic [DISC_W-1:0] rem_i,
  input  wire logic [ROOT_W-1:0] root_i,
  input  wire side_t             side_i,
  output logic                   vld_o,
  output logic [DISC_W-1:0]      rem_o,
  output logic [ROOT_W-1:0]      root_o,
  output side_t                  side_o
);

  logic [DISC_W+1:0] trial;
  logic              take;

  // (r + 2^K)^2 - r^2 = r*2^(K+1) + 2^(2K)
  always_comb begin
    trial = ({{(DISC_W+2-ROOT_W){1'b0}}, root_i} << (K + 1))
            + ((DISC_W+2)'(1) << (2 * K));
    take  = {2'b00, rem_i} >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      if (take) begin
        rem_o  <= rem_i - trial[DISC_W-1:0];
        root_o <= root_i | (ROOT_W'(1) << K);
      end else begin
        rem_o  <= rem_i;
        root_o <= root_i;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/sssh_div_cell.sv */
// One quotient-bit cell of the pipelined restoring divider chain.
// Depends on sssh_pkg.
`default_nettype none

module sssh_div_cell import sssh_pkg::*; #(
  parameter int J = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             vld_i,
  input  wire logic [NUM_W-1:0] rem_i,
  input  wire logic [18:0]      q_i,
  input  wire side_t            side_i,
  output logic                  vld_o,
  output logic [NUM_W-1:0]      rem_o,
  output logic [18:0]           q_o,
  output side_t                 side_o
);

  logic [NUM_W-1:0] dsh;
  logic             take;

  always_comb begin
    dsh  = {{(NUM_W-32){1'b0}}, side_i.a} << J;
    take = rem_i >= dsh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o <= side_i;
      if (take) begin
        rem_o <= rem_i - dsh;
        q_o   <= q_i | (19'd1 << J);
      end else begin
        rem_o <= rem_i;
        q_o   <= q_i;
      end
    end
  end

endmodule

`default_nettype wire
